### hw/rtl/egbr_pkg.sv
// ----------------------------------------------------------------------------
// egbr_pkg
// Shared constants, request and status codes, and the command and status
// bundles between the controller and the datapath of the bit reader.
// ----------------------------------------------------------------------------
package egbr_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int TOTAL_W      = ADDR_W + 1;
  localparam int POS_W        = TOTAL_W + 3;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_UE     = 3'd1;
  localparam logic [2:0] REQ_SE     = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_PEEK   = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EOD   = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [5:0] MAX_FIXED = 6'd32;
  localparam logic [5:0] MAX_ZEROS = 6'd31;

  typedef struct packed {
    logic       load;
    logic       append;
    logic       clear;
    logic       fail;
    logic [1:0] fail_code;
    logic       scan_init;
    logic       scan_step;
    logic       start_info;
    logic       start_fixed;
    logic       read_step;
    logic       form_code;
    logic       finish;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       fixed_short;
    logic       cur_end;
    logic       scan_long;
    logic       scan_hit;
    logic       code_short;
    logic       left_zero;
    logic       out_free;
  } dp_stat_t;

endpackage

### hw/rtl/egbr_ram.sv
// ----------------------------------------------------------------------------
// egbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module egbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/egbr_dp.sv
// ----------------------------------------------------------------------------
// egbr_dp
// Datapath: byte buffer, read position, byte-wide zero scan and field
// gather, code formation and the output register.
// ----------------------------------------------------------------------------
module egbr_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  egbr_pkg::dp_cmd_t       cmd,
  output egbr_pkg::dp_stat_t      stat,
  input  logic [2:0]              req_type,
  input  logic [7:0]              byte_in,
  input  logic [5:0]              bit_count,
  output logic signed [32:0]      value,
  output logic [5:0]              bits_used,
  output logic [1:0]              status,
  output logic                    out_valid,
  input  logic                    out_stall
);
  import egbr_pkg::*;

  logic [2:0]         req;
  logic [7:0]         byte_hold;
  logic [5:0]         cnt;
  logic [TOTAL_W-1:0] total;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   cur;
  logic [4:0]         zeros;
  logic [5:0]         left;
  logic [31:0]        acc;
  logic [32:0]        rvalue;
  logic [5:0]         rused;
  logic [1:0]         rstat;

  logic [7:0]         rdata;
  logic [POS_W-1:0]   total_bits;
  logic [2:0]         off;
  logic [3:0]         avail;
  logic [7:0]         sh;
  logic [3:0]         lead;
  logic [5:0]         zsum;
  logic [3:0]         take;
  logic [7:0]         chunk;
  logic [5:0]         code_len;
  logic [32:0]        half;

  egbr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (total[ADDR_W-1:0]),
    .wdata (byte_hold),
    .raddr (cur[ADDR_W+2:3]),
    .rdata (rdata)
  );

  assign total_bits = {total, 3'b000};
  assign off        = cur[2:0];
  assign avail      = 4'd8 - {1'b0, off};
  assign sh         = rdata << off;
  assign code_len   = {zeros, 1'b1};
  assign half       = {1'b0, acc[31:1]} + 33'd0;

  always_comb begin
    lead = avail;
    for (int i = 0; i < 8; i++) begin
      if (sh[i]) begin
        lead = 4'(7 - i);
      end
    end
  end

  assign zsum  = 6'(zeros) + 6'(lead);
  assign take  = (left < 6'(avail)) ? left[3:0] : avail;
  assign chunk = sh >> (4'd8 - take);

  always_comb begin
    stat.op          = req;
    stat.full        = (total == TOTAL_W'(BUFFER_BYTES));
    stat.fixed_short = ((POS_W+1)'(pos) + (POS_W+1)'(cnt)) > (POS_W+1)'(total_bits);
    stat.cur_end     = (cur >= total_bits);
    stat.scan_long   = (zsum > MAX_ZEROS);
    stat.scan_hit    = (sh != 8'd0);
    stat.code_short  = ((POS_W+1)'(pos) + (POS_W+1)'(code_len)) > (POS_W+1)'(total_bits);
    stat.left_zero   = (left == 6'd0);
    stat.out_free    = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      pos   <= '0;
    end else begin
      if (cmd.clear) begin
        total <= '0;
        pos   <= '0;
      end else if (cmd.append) begin
        total <= total + TOTAL_W'(1);
      end else if (cmd.finish && rstat == ST_OK) begin
        if (req == REQ_UE || req == REQ_SE) begin
          pos <= pos + POS_W'(code_len);
        end else if (req == REQ_READ) begin
          pos <= pos + POS_W'(cnt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req       <= req_type;
      byte_hold <= byte_in;
      cnt       <= (bit_count > MAX_FIXED) ? MAX_FIXED : bit_count;
      rvalue    <= '0;
      rused     <= '0;
      rstat     <= ST_OK;
    end
    if (cmd.fail) begin
      rstat <= cmd.fail_code;
    end
    if (cmd.scan_init) begin
      cur   <= pos;
      zeros <= '0;
    end
    if (cmd.scan_step) begin
      zeros <= zsum[4:0];
      if (!stat.scan_hit) begin
        cur <= cur + POS_W'(avail);
      end
    end
    if (cmd.start_info) begin
      cur  <= pos + POS_W'(zeros) + POS_W'(1);
      left <= 6'(zeros);
      acc  <= '0;
    end
    if (cmd.start_fixed) begin
      cur  <= pos;
      left <= cnt;
      acc  <= '0;
    end
    if (cmd.read_step) begin
      acc  <= (acc << take) | {24'd0, chunk};
      cur  <= cur + POS_W'(take);
      left <= left - 6'(take);
    end
    if (cmd.form_code) begin
      acc <= acc + ~(32'hFFFF_FFFF << zeros);
    end
    if (cmd.finish) begin
      if (req == REQ_SE) begin
        rvalue <= (acc[0] ? half : ~half) + 33'd1;
        rused  <= code_len;
      end else if (req == REQ_UE) begin
        rvalue <= {1'b0, acc};
        rused  <= code_len;
      end else begin
        rvalue <= {1'b0, acc};
        rused  <= cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value     <= rvalue;
      bits_used <= rused;
      status    <= rstat;
    end
  end

endmodule

### hw/rtl/egbr_ctrl.sv
// ----------------------------------------------------------------------------
// egbr_ctrl
// Controller: sequences request decode, zero scan, field gather, code
// formation and result hand-off.
// ----------------------------------------------------------------------------
module egbr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output egbr_pkg::dp_cmd_t   cmd,
  input  egbr_pkg::dp_stat_t  stat
);
  import egbr_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_SCAN_ADDR = 4'd2;
  localparam logic [3:0] S_SCAN      = 4'd3;
  localparam logic [3:0] S_CHECK     = 4'd4;
  localparam logic [3:0] S_RD_ADDR   = 4'd5;
  localparam logic [3:0] S_RD        = 4'd6;
  localparam logic [3:0] S_FORM      = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       is_code;

  assign in_stall = (state != S_IDLE);
  assign is_code  = (stat.op == REQ_UE) || (stat.op == REQ_SE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (stat.op)
          REQ_APPEND: begin
            if (stat.full) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          REQ_UE, REQ_SE: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN_ADDR;
          end
          REQ_READ, REQ_PEEK: begin
            if (stat.fixed_short) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = ST_EOD;
            end else begin
              cmd.start_fixed = 1'b1;
              state_next      = S_RD_ADDR;
            end
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN_ADDR: begin
        if (stat.cur_end) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_EOD;
          state_next    = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_long) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_LONG;
          state_next    = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = stat.scan_hit ? S_CHECK : S_SCAN_ADDR;
        end
      end
      S_CHECK: begin
        if (stat.code_short) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_EOD;
          state_next    = S_DONE;
        end else begin
          cmd.start_info = 1'b1;
          state_next     = S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        if (stat.left_zero) begin
          state_next = is_code ? S_FORM : S_FINISH;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.read_step = 1'b1;
        state_next    = S_RD_ADDR;
      end
      S_FORM: begin
        cmd.form_code = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/exp_golomb_bit_reader.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader
// Exp-Golomb and fixed-field bit reader over a loaded byte buffer, MSB first.
// Sequence: append, clear and unused codes go from decode to the result;
//   fixed read/peek gather each byte touched; ue/se scan bytes for the zero
//   run, gather the info bits and form the code. Each byte takes an address
//   state and a data state for the buffer RAM's registered read port.
// Throughput: one item in flight; the next is taken once the result is loaded.
// Reset clears position, byte count and the controller; buffer contents are
//   undefined until written and are never read before being written.
// ----------------------------------------------------------------------------
module exp_golomb_bit_reader (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [7:0]         byte_in,
  input  logic [5:0]         bit_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] value,
  output logic [5:0]         bits_used,
  output logic [1:0]         status
);
  import egbr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  egbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  egbr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (req_type),
    .byte_in   (byte_in),
    .bit_count (bit_count),
    .value     (value),
    .bits_used (bits_used),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

### hw/rtl/egbr_checker.sv
// ----------------------------------------------------------------------------
// egbr_checker
// Port-level checks on the bit reader, attached to the top level by bind.
// ----------------------------------------------------------------------------
module egbr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [32:0] value,
  input logic [5:0]         bits_used,
  input logic [1:0]         status
);
  import egbr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(bits_used)
      && $stable(status))
    else $error("result changed while stalled");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == 33'sd0 && bits_used == 6'd0)
    else $error("failed item carries a value or length");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_full_no_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> bits_used == 6'd0)
    else $error("buffer full result with nonzero length");

endmodule

bind exp_golomb_bit_reader egbr_checker u_egbr_checker (.*);
